// ===== src/page_table_walk_va_to_pa_macros.svh =====
// Assertion macros for the table walker.
// PTW_ASSERT_SAME: the consequent holds in the cycle of the antecedent.
// PTW_ASSERT_NEXT: the consequent holds in the cycle after the antecedent.
`ifndef PAGE_TABLE_WALK_VA_TO_PA_MACROS_SVH
`define PAGE_TABLE_WALK_VA_TO_PA_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PTW_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("table walker check failed");
`define PTW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("table walker check failed");
`else
`define PTW_ASSERT_SAME(label, clk, rst, ante, cons)
`define PTW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/ptw_pkg.sv =====
`default_nettype none
package ptw_pkg;

  localparam int PHYS_ADDR_BITS = 48;
  localparam int ADDR_W         = 48;
  localparam int VA_W           = 64;
  localparam int DESC_W         = 64;
  localparam int IDX_W          = 13;   // widest per-level index (64K granule)

  // result kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_FAULT = 2'd2;

  // operations
  localparam logic OP_START = 1'b0;
  localparam logic OP_REPLY = 1'b1;

  // granule codes
  localparam logic [1:0] GRAN_4K  = 2'd0;
  localparam logic [1:0] GRAN_16K = 2'd1;
  localparam logic [1:0] GRAN_64K = 2'd2;

  // descriptor types
  localparam logic [1:0] DESC_TABLE = 2'd3;
  localparam logic [1:0] DESC_BLOCK = 2'd1;

  // register indexes (word address paddr[3:2])
  localparam logic [1:0] REG_GRANULE = 2'd0;
  localparam logic [1:0] REG_LEVELS  = 2'd1;
  localparam logic [1:0] REG_VA_BITS = 2'd2;

  localparam logic [1:0] RST_GRANULE = GRAN_4K;
  localparam logic [2:0] RST_LEVELS  = 3'd4;
  localparam logic [5:0] RST_VA_BITS = 6'd48;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] read_address;
    logic [ADDR_W-1:0] phys_addr;
  } result_t;

  function automatic logic [4:0] page_shift(input logic [1:0] gran);
    logic [4:0] ps;
    case (gran)
      GRAN_16K: ps = 5'd14;
      GRAN_64K: ps = 5'd16;
      default:  ps = 5'd12;
    endcase
    return ps;
  endfunction

  // shift of the index slice for level lv: per * (4 - lv) + 3
  function automatic logic [5:0] index_shift(input logic [3:0] per, input logic [1:0] lv);
    logic [6:0] t;
    t = 7'(per) * 7'(3'd4 - {1'b0, lv}) + 7'd3;
    return 6'(t);
  endfunction

  // bits covered by a block at level lv: (3 - lv) * per
  function automatic logic [5:0] block_span(input logic [3:0] per, input logic [1:0] lv);
    logic [6:0] t;
    t = 7'(per) * 7'(2'd3 - lv);
    return 6'(t);
  endfunction

  // bits lo .. hi-1 set
  function automatic logic [63:0] bit_range64(input logic [5:0] lo, input logic [6:0] hi);
    logic [63:0] m;
    for (int i = 0; i < 64; i++) begin
      m[i] = (7'(i) >= {1'b0, lo}) && (7'(i) < hi);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== src/page_table_walk_va_to_pa.sv =====
// Channel   Dir  Handshake          Payload
// s_*       in   tvalid/tready      tuser: operation; tdata: virt_addr, table_base, descriptor
// m_*       out  tvalid/tready      tuser: kind; tdata: read_address, phys_addr
// APB       in   psel/penable/pwrite  granule_select, table_levels, va_bits
//
// One beat per cycle sustained while m_* is not stalled; a beat passes through the
// input register and then the output register, which drives m_*.
// The walk state (busy, level, held address) advances as a beat leaves the
// input register, so replies may follow one another with no gap.
// Reset (rst, synchronous) empties both registers, idles the walker and loads
// the register defaults: 4K granule, four levels, 48-bit addresses.
// A stalled m_* holds its beat; s_tready drops only when the input register is
// full with a result-bearing beat and the output register cannot drain.
`default_nettype none
module page_table_walk_va_to_pa (
  input  wire logic         clk,
  input  wire logic         rst,
  // stream in
  input  wire logic         s_tvalid,
  output      logic         s_tready,
  input  wire logic [175:0] s_tdata,   // virt_addr[63:0], table_base[111:64], descriptor[175:112]
  input  wire logic [0:0]   s_tuser,   // operation[0]
  // stream out
  output      logic         m_tvalid,
  input  wire logic         m_tready,
  output      logic [95:0]  m_tdata,   // read_address[47:0], phys_addr[95:48]
  output      logic [1:0]   m_tuser,   // kind[1:0]
  // register port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output      logic [31:0]  prdata,
  output      logic         pready
);

  `include "page_table_walk_va_to_pa_macros.svh"

  // ---------------------------------------------------------------------------
  // Configuration registers, stored raw and saturated where used
  // ---------------------------------------------------------------------------
  logic [1:0] granule_select;
  logic [2:0] table_levels;
  logic [5:0] va_bits;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      granule_select <= ptw_pkg::RST_GRANULE;
      table_levels   <= ptw_pkg::RST_LEVELS;
      va_bits        <= ptw_pkg::RST_VA_BITS;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        ptw_pkg::REG_GRANULE: granule_select <= pwdata[1:0];
        ptw_pkg::REG_LEVELS:  table_levels   <= pwdata[2:0];
        ptw_pkg::REG_VA_BITS: va_bits        <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ptw_pkg::REG_GRANULE: prdata = {30'd0, granule_select};
      ptw_pkg::REG_LEVELS:  prdata = {29'd0, table_levels};
      ptw_pkg::REG_VA_BITS: prdata = {26'd0, va_bits};
      default:              prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                            in_valid;
  logic                            in_op;
  logic [ptw_pkg::VA_W-1:0]        in_va;
  logic [ptw_pkg::ADDR_W-1:0]      in_base;
  logic [ptw_pkg::DESC_W-1:0]      in_desc;
  logic                            in_advance;
  logic                            in_load;

  // ---------------------------------------------------------------------------
  // Walk state
  // ---------------------------------------------------------------------------
  logic                            walk_busy;
  logic                            walk_busy_next;
  logic [1:0]                      current_level;
  logic [1:0]                      current_level_next;
  logic [ptw_pkg::VA_W-1:0]        held_virt_addr;

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic                            out_valid;
  ptw_pkg::result_t                out_res;
  ptw_pkg::result_t                res;
  logic                            has_result;
  logic                            out_free;

  assign out_free   = !out_valid || m_tready;
  assign in_advance = in_valid && (!has_result || out_free);
  assign s_tready   = !in_valid || in_advance;
  assign in_load    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= 1'b1;
    end else if (in_advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_op   <= s_tuser[0];
      in_va   <= s_tdata[63:0];
      in_base <= s_tdata[111:64];
      in_desc <= s_tdata[175:112];
    end
  end

  // ---------------------------------------------------------------------------
  // Translation step
  // ---------------------------------------------------------------------------
  logic [4:0]                 ps;
  logic [3:0]                 per;
  logic [2:0]                 lvl_count;
  logic [5:0]                 va_w;
  logic [63:0]                floor_mask;
  logic                       is_start;
  logic [ptw_pkg::VA_W-1:0]   va_use;
  logic [1:0]                 read_level;
  logic [ptw_pkg::ADDR_W-1:0] read_base;
  logic [5:0]                 idx_shift;
  logic [ptw_pkg::IDX_W-1:0]  idx;
  logic [ptw_pkg::ADDR_W-1:0] entry_addr;
  logic [1:0]                 desc_type;
  logic [ptw_pkg::ADDR_W-1:0] table_pa;
  logic [5:0]                 span;
  logic [5:0]                 block_lo;
  logic [63:0]                final_pa;
  logic [63:0]                page_off;

  always_comb begin
    ps  = ptw_pkg::page_shift(granule_select);
    per = 4'(ps - 5'd3);

    // saturate level count to 1..4 and address width to 25..52
    if (table_levels < 3'd1)      lvl_count = 3'd1;
    else if (table_levels > 3'd4) lvl_count = 3'd4;
    else                          lvl_count = table_levels;
    if (va_bits < 6'd25)          va_w = 6'd25;
    else if (va_bits > 6'd52)     va_w = 6'd52;
    else                          va_w = va_bits;
    floor_mask = ptw_pkg::bit_range64(va_w, 7'd64);

    is_start  = (in_op == ptw_pkg::OP_START);
    va_use    = is_start ? in_va : held_virt_addr;
    desc_type = in_desc[1:0];
    page_off  = va_use & ptw_pkg::bit_range64(6'd0, 7'(ps));

    // table pointer or page frame: bits ps .. top of physical space
    table_pa = in_desc[ptw_pkg::ADDR_W-1:0]
             & ptw_pkg::ADDR_W'(ptw_pkg::bit_range64(6'(ps), 7'(ptw_pkg::PHYS_ADDR_BITS)));

    // block: frame bits from the descriptor, the rest from the address
    span     = ptw_pkg::block_span(per, current_level);
    block_lo = span + 6'(ps);

    read_level         = 2'(3'd4 - lvl_count);
    read_base          = in_base;
    walk_busy_next     = walk_busy;
    current_level_next = current_level;
    has_result         = 1'b1;
    final_pa           = 64'd0;
    res.kind           = ptw_pkg::KIND_FAULT;
    res.read_address   = '0;
    res.phys_addr      = '0;

    if (is_start) begin
      if ((va_use & floor_mask) != floor_mask) begin
        walk_busy_next = 1'b0;
      end else begin
        walk_busy_next     = 1'b1;
        current_level_next = read_level;
        res.kind           = ptw_pkg::KIND_READ;
      end
    end else if (!walk_busy) begin
      has_result = 1'b0;
    end else if (desc_type == ptw_pkg::DESC_TABLE) begin
      if (current_level == 2'd3) begin
        walk_busy_next = 1'b0;
        final_pa       = {16'd0, table_pa};
        res.kind       = (final_pa == 64'd0) ? ptw_pkg::KIND_FAULT : ptw_pkg::KIND_DONE;
      end else begin
        read_level         = current_level + 2'd1;
        read_base          = table_pa;
        current_level_next = read_level;
        res.kind           = ptw_pkg::KIND_READ;
      end
    end else if (desc_type == ptw_pkg::DESC_BLOCK && current_level != 2'd3) begin
      walk_busy_next = 1'b0;
      final_pa = ({16'd0, in_desc[ptw_pkg::ADDR_W-1:0]}
                  & ptw_pkg::bit_range64(block_lo, 7'(ptw_pkg::PHYS_ADDR_BITS)))
               | (va_use & ptw_pkg::bit_range64(6'(ps), 7'(block_lo)));
      res.kind = (final_pa == 64'd0) ? ptw_pkg::KIND_FAULT : ptw_pkg::KIND_DONE;
    end else begin
      walk_busy_next = 1'b0;
    end

    // descriptor address for the level asked next
    idx_shift  = ptw_pkg::index_shift(per, read_level);
    idx        = ptw_pkg::IDX_W'(va_use >> idx_shift) & ~({ptw_pkg::IDX_W{1'b1}} << per);
    entry_addr = read_base + ptw_pkg::ADDR_W'({idx, 3'b000});

    if (res.kind == ptw_pkg::KIND_READ) begin
      res.read_address = entry_addr;
    end
    if (res.kind == ptw_pkg::KIND_DONE) begin
      res.phys_addr = ptw_pkg::ADDR_W'(final_pa | page_off);
    end
  end

  // advance the walk as each beat leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_busy     <= 1'b0;
      current_level <= 2'd0;
    end else if (in_advance) begin
      walk_busy     <= walk_busy_next;
      current_level <= current_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_virt_addr <= '0;
    end else if (in_advance && is_start) begin
      held_virt_addr <= in_va;
    end
  end

  // output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_advance && has_result) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && has_result) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.kind;
  assign m_tdata  = {out_res.phys_addr, out_res.read_address};

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `PTW_ASSERT_SAME(a_rd_only_on_read, clk, rst,
    m_tvalid && m_tuser != ptw_pkg::KIND_READ, m_tdata[47:0] == 48'd0)
  `PTW_ASSERT_SAME(a_pa_only_on_done, clk, rst,
    m_tvalid && m_tuser != ptw_pkg::KIND_DONE, m_tdata[95:48] == 48'd0)
  `PTW_ASSERT_NEXT(a_idle_after_end, clk, rst,
    in_advance && has_result && res.kind != ptw_pkg::KIND_READ, !walk_busy)
  `PTW_ASSERT_SAME(a_stall_cause, clk, rst,
    !s_tready, in_valid && out_valid && !m_tready)

endmodule
`default_nettype wire

// ===== test/ptw_checker.sv =====
`timescale 1ns / 100ps
module ptw_checker
  import ptw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [175:0] s_tdata,   // virt_addr[63:0], table_base[111:64], descriptor[175:112]
  input  logic [0:0]   s_tuser,   // operation[0]
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [95:0]  m_tdata,   // read_address[47:0], phys_addr[95:48]
  input  logic [1:0]   m_tuser,   // kind[1:0]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output int           errors,
  output int           outstanding
);

  localparam int MAX_PRINTED = 40;

  logic [1:0]  cfg_gran;
  logic [2:0]  cfg_levels;
  logic [5:0]  cfg_va_bits;

  logic        wk_busy;
  logic [1:0]  wk_level;
  logic [63:0] wk_va;

  result_t     walk_results_q[$];

  function automatic int gran_shift();
    case (cfg_gran)
      GRAN_16K: return 14;
      GRAN_64K: return 16;
      default:  return 12;
    endcase
  endfunction

  function automatic int depth_sat();
    if (cfg_levels < 3'd1) return 1;
    if (cfg_levels > 3'd4) return 4;
    return int'(cfg_levels);
  endfunction

  function automatic logic [63:0] lowest_kernel_va();
    int w;
    w = int'(cfg_va_bits);
    if (w < 25) w = 25;
    if (w > 52) w = 52;
    return ~((64'd1 << w) - 64'd1);
  endfunction

  // bits lo up to the top of the physical space; empty once lo reaches it
  function automatic logic [63:0] frame_mask(input int lo);
    if (lo >= PHYS_ADDR_BITS) return 64'd0;
    return ((64'd1 << PHYS_ADDR_BITS) - 64'd1) & ~((64'd1 << lo) - 64'd1);
  endfunction

  function automatic logic [63:0] desc_slot_addr(input logic [63:0] base, input int lv);
    int          per;
    int          sh;
    logic [63:0] idx;
    per = gran_shift() - 3;
    sh  = per * (4 - lv) + 3;
    idx = (wk_va >> sh) & ((64'd1 << per) - 64'd1);
    return base + (idx << 3);
  endfunction

  function automatic result_t make_result(input logic [1:0] k, input logic [63:0] rd,
                                          input logic [63:0] pa);
    result_t r;
    r.kind         = k;
    r.read_address = rd[ADDR_W-1:0];
    r.phys_addr    = pa[ADDR_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < MAX_PRINTED) $display("[%0t] ptw mismatch: %s", $time, what);
    errors++;
  endtask

  // end the walk: zero address faults, else add the in-page offset
  task automatic close_walk(input logic [63:0] pa);
    wk_busy = 1'b0;
    if (pa == 64'd0) begin
      walk_results_q.push_back(make_result(KIND_FAULT, 64'd0, 64'd0));
    end else begin
      pa = pa + (wk_va & ((64'd1 << gran_shift()) - 64'd1));
      walk_results_q.push_back(make_result(KIND_DONE, 64'd0, pa));
    end
  endtask

  task automatic predict_walk_step(input logic op, input logic [63:0] va,
                                   input logic [47:0] base, input logic [63:0] desc);
    int          ps;
    int          per;
    int          span;
    logic [1:0]  lv;
    logic [63:0] pa;
    ps  = gran_shift();
    per = ps - 3;
    if (op == OP_START) begin
      wk_va = va;
      if (va < lowest_kernel_va()) begin
        wk_busy = 1'b0;
        walk_results_q.push_back(make_result(KIND_FAULT, 64'd0, 64'd0));
      end else begin
        wk_busy  = 1'b1;
        wk_level = 2'(4 - depth_sat());
        walk_results_q.push_back(
          make_result(KIND_READ, desc_slot_addr({16'd0, base}, int'(wk_level)), 64'd0));
      end
    end else if (wk_busy) begin
      lv = wk_level;
      if (desc[1:0] == DESC_TABLE) begin
        pa = desc & frame_mask(ps);
        if (lv == 2'd3) begin
          close_walk(pa);
        end else begin
          wk_level = lv + 2'd1;
          walk_results_q.push_back(
            make_result(KIND_READ, desc_slot_addr(pa, int'(wk_level)), 64'd0));
        end
      end else if (desc[1:0] == DESC_BLOCK && lv != 2'd3) begin
        span = (3 - int'(lv)) * per;
        pa   = (desc & frame_mask(span + ps)) + (wk_va & (((64'd1 << span) - 64'd1) << ps));
        close_walk(pa);
      end else begin
        wk_busy = 1'b0;
        walk_results_q.push_back(make_result(KIND_FAULT, 64'd0, 64'd0));
      end
    end
  endtask

  task automatic check_result_beat();
    result_t got;
    result_t want;
    got = make_result(m_tuser, {16'd0, m_tdata[47:0]}, {16'd0, m_tdata[95:48]});
    if (walk_results_q.size() == 0) begin
      report_mismatch($sformatf("unexpected beat kind %0d rd %h pa %h",
                                got.kind, got.read_address, got.phys_addr));
    end else begin
      want = walk_results_q.pop_front();
      if (got.kind != want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.read_address != want.read_address)
        report_mismatch($sformatf("read_address %h, want %h",
                                  got.read_address, want.read_address));
      if (got.phys_addr != want.phys_addr)
        report_mismatch($sformatf("phys_addr %h, want %h", got.phys_addr, want.phys_addr));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_gran    = RST_GRANULE;
      cfg_levels  = RST_LEVELS;
      cfg_va_bits = RST_VA_BITS;
      wk_busy     = 1'b0;
      wk_level    = 2'd0;
      wk_va       = 64'd0;
      errors      = 0;
      walk_results_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_GRANULE: cfg_gran    = pwdata[1:0];
          REG_LEVELS:  cfg_levels  = pwdata[2:0];
          REG_VA_BITS: cfg_va_bits = pwdata[5:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        predict_walk_step(s_tuser[0], s_tdata[63:0], s_tdata[111:64], s_tdata[175:112]);
      if (m_tvalid && m_tready)
        check_result_beat();
    end
    outstanding <= walk_results_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the table walker bench. This module only makes stimulus and gives the
// verdict; ptw_checker watches both streams and the register port, predicts
// every result beat and counts mismatches.
//
// Flow: reset, a short directed sweep at the reset settings, then phases of
// random walks, each phase under its own register settings (out-of-range
// codes included, so the saturation rules get exercised). Registers are only
// written once every expected beat has come back and the input register has
// had time to drain a trailing reply that yields nothing.
module tb_top;
  import ptw_pkg::*;

  localparam int NUM_PHASES      = 11;
  localparam int FIXED_PHASES    = 9;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int RX_HOLD_CYCLES  = 80;   // long enough to back the block up
  localparam int DRAIN_CYCLES    = 6;    // input and output registers plus margin
  localparam int END_CYCLES      = 8;

  // descriptor types that always fault
  localparam logic [1:0] DESC_INVALID  = 2'd0;
  localparam logic [1:0] DESC_RESERVED = 2'd2;

  // per-phase register settings; the tail ones push the codes out of range
  localparam int PH_GRAN   [FIXED_PHASES] = '{0, 1, 2, 3, 2, 1, 0, 2, 1};
  localparam int PH_LEVELS [FIXED_PHASES] = '{4, 3, 2, 4, 1, 4, 0, 7, 5};
  localparam int PH_VA     [FIXED_PHASES] = '{48, 47, 42, 39, 25, 52, 0, 63, 24};
  localparam int GAP_PCT   [3] = '{0, 12, 35};
  localparam int STALL_PCT [3] = '{20, 0, 10};

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [175:0] s_tdata;   // virt_addr[63:0], table_base[111:64], descriptor[175:112]
  logic [0:0]   s_tuser;   // operation[0]
  logic         m_tvalid;
  logic         m_tready;
  logic [95:0]  m_tdata;   // read_address[47:0], phys_addr[95:48]
  logic [1:0]   m_tuser;   // kind[1:0]
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  int           errors;
  int           outstanding;

  // stimulus-side view of the settings, used only to shape the walks
  int           walk_depth;
  logic [63:0]  va_floor;

  int           items_sent;
  int           tx_gap_pct;
  int           rx_stall_pct;
  logic         rx_hold_req;
  int           rx_hold_left;
  int           rx_stall_left;
  logic         rx_ready_next;

  page_table_walk_va_to_pa DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ptw_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: a long hold when asked, otherwise random stall bursts
  // at the rate the current phase sets. One assignment per edge.
  initial begin
    m_tready      <= 1'b0;
    rx_hold_left  = 0;
    rx_stall_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_left = RX_HOLD_CYCLES;
        rx_hold_req  = 1'b0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        rx_ready_next = 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        rx_ready_next = 1'b0;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        rx_stall_left = $urandom_range(1, 13) - 1;
        rx_ready_next = 1'b0;
      end else begin
        rx_ready_next = 1'b1;
      end
      m_tready <= rx_ready_next;
    end
  end

  // Hold the beat until the handshake completes.
  task automatic send_beat(input logic op, input logic [63:0] va, input logic [47:0] base,
                           input logic [63:0] desc);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {desc, base, va};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid for a random burst now and then, then offer the beat.
  task automatic offer_beat(input logic op, input logic [63:0] va, input logic [47:0] base,
                            input logic [63:0] desc);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    send_beat(op, va, base, desc);
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Setup and access cycle; the bus is left selected so writes can follow
  // back to back.
  task automatic apb_write(input logic [1:0] idx, input int value);
    logic [31:0] wdata;
    wdata = $urandom;
    case (idx)
      REG_GRANULE: wdata[1:0] = value[1:0];
      REG_LEVELS:  wdata[2:0] = value[2:0];
      default:     wdata[5:0] = value[5:0];
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // Write all three registers with the block idle and refresh the local view.
  task automatic set_config(input int gran, input int levels, input int vab);
    int w;
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    apb_write(REG_GRANULE, gran);
    apb_write(REG_LEVELS, levels);
    apb_write(REG_VA_BITS, vab);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    walk_depth = (levels < 1) ? 1 : (levels > 4) ? 4 : levels;
    w          = (vab < 25) ? 25 : (vab > 52) ? 52 : vab;
    va_floor   = ~((64'd1 << w) - 64'd1);
  endtask

  // One walk: mostly a well-formed start followed by table descriptors down
  // to a page, with blocks, faulting types, zero addresses, abandoned walks
  // and stray replies mixed in.
  task automatic run_walk();
    logic [63:0] va;
    logic [63:0] desc;
    logic [47:0] base;
    int          pick;
    int          lv;
    pick = $urandom_range(0, 99);
    if (pick < 8)       va = {$urandom, $urandom};
    else if (pick < 11) va = va_floor - 64'd1;
    else if (pick < 14) va = va_floor;
    else                va = va_floor | {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 5)       base = '0;
    else if (pick < 10) base = '1;
    else                base = 48'({$urandom, $urandom});
    offer_beat(OP_START, va, base, {$urandom, $urandom});
    for (int k = 0; k < walk_depth; k++) begin
      lv = 4 - walk_depth + k;
      // abandon now and then: the next start drops the walk
      if ($urandom_range(0, 99) < 4) return;
      desc = {$urandom, $urandom};
      if ($urandom_range(0, 19) == 0) desc[47:2] = '0;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        desc[1:0] = (pick < 3) ? DESC_INVALID : DESC_RESERVED;
        offer_beat(OP_REPLY, {$urandom, $urandom}, 48'($urandom), desc);
        break;
      end else if (pick < 23 && (lv < 3 || pick < 8)) begin
        // block at an upper level; at the last level this is the reserved case
        desc[1:0] = DESC_BLOCK;
        offer_beat(OP_REPLY, {$urandom, $urandom}, 48'($urandom), desc);
        break;
      end else begin
        desc[1:0] = DESC_TABLE;
        offer_beat(OP_REPLY, {$urandom, $urandom}, 48'($urandom), desc);
      end
    end
    if ($urandom_range(0, 19) == 0)
      offer_beat(OP_REPLY, {$urandom, $urandom}, 48'($urandom), {$urandom, $urandom});
  endtask

  // Stimulus and verdict.
  initial begin
    int   phase_end;
    int   mid;
    logic pause_due;
    rst          <= 1'b1;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    s_tuser      <= OP_START;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    items_sent   = 0;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    rx_hold_req  = 1'b0;
    walk_depth   = 4;
    va_floor     = 64'hFFFF_0000_0000_0000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed sweep at the reset settings: 4K granule, four levels, 48 bits.
    send_beat(OP_REPLY, '0, '0, '1);                          // reply while idle
    send_beat(OP_START, 64'd0, '1, '0);                       // user address faults
    send_beat(OP_START, '1, '1, '0);                          // full walk, all ones
    repeat (4) send_beat(OP_REPLY, '0, '0, '1);
    send_beat(OP_START, va_floor, '0, '0);                    // lowest kernel address
    send_beat(OP_REPLY, '0, '0, 64'hFFFF_FFFF_FFFF_FFFD);     // block at the top level
    send_beat(OP_START, va_floor | 64'h1234_5678_9ABC, 48'h8000_0000, '0);
    send_beat(OP_REPLY, '0, '0, {62'h10_0000, DESC_INVALID});
    send_beat(OP_START, '1, 48'h1234_5678_9ABC, '0);
    send_beat(OP_REPLY, '0, '0, {62'h2000_0000_0000_0400, DESC_RESERVED});
    send_beat(OP_START, '1, 48'h0F0F_0F0F_0F0F, '0);          // walk dropped by the next start
    send_beat(OP_START, va_floor, 48'h1000, '0);
    send_beat(OP_REPLY, '0, '0, {62'd0, DESC_BLOCK});         // block at address zero
    send_beat(OP_START, va_floor - 64'd1, '1, '0);            // just below the bound
    send_beat(OP_START, '1, '0, '0);                          // page at address zero
    repeat (4) send_beat(OP_REPLY, '0, '0, {62'd0, DESC_TABLE});

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < FIXED_PHASES)
        set_config(PH_GRAN[ph], PH_LEVELS[ph], PH_VA[ph]);
      else
        set_config($urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 63));
      // no random gaps or stalls in the closing phase
      tx_gap_pct   = (ph == NUM_PHASES - 1) ? 0 : GAP_PCT[ph % 3];
      rx_stall_pct = (ph == NUM_PHASES - 1) ? 0 : STALL_PCT[ph % 3];
      if (ph == 1 || ph == 5) rx_hold_req = 1'b1;
      pause_due = (ph % 4 == 2);
      phase_end = items_sent + ITEMS_PER_PHASE;
      mid       = items_sent + ITEMS_PER_PHASE / 2;
      while (items_sent < phase_end) begin
        run_walk();
        // hold off the sender until every result has come back
        if (pause_due && items_sent >= mid) begin
          wait_all_results();
          pause_due = 1'b0;
        end
      end
    end

    wait_all_results();
    repeat (END_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ptw_pkg.sv
src/page_table_walk_va_to_pa.sv
test/ptw_checker.sv
test/tb_top.sv
